[src/assert_macros.svh]
// Assertion macros shared by the ray/ellipsoid intersection RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define REI_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ray ellipsoid intersect assertion failed");
`define REI_ASSERT_NORST(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ray ellipsoid intersect assertion failed");
`else
`define REI_ASSERT(name, clk, rst, prop)
`define REI_ASSERT_NORST(name, clk, prop)
`endif
`endif

[src/rei_pkg.sv]
// Package for the ray/ellipsoid intersection block.
// Holds the 64-bit intermediate format helpers and the register index codes.
// No dependencies.
`default_nettype none

package rei_pkg;

   localparam int IW = 64;
   localparam logic [IW-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [IW:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [IW:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS_X = 3'd3,
      CSR_RADIUS_Y = 3'd4,
      CSR_RADIUS_Z = 3'd5
   } csr_index_type;

   function automatic logic [IW-1:0] neg64(logic [IW-1:0] x);
      return 64'd0 - x;
   endfunction

   function automatic logic [IW-2:0] mag63(logic [IW-1:0] x);
      logic [IW-1:0] m;
      m = x[IW-1] ? (64'd0 - x) : x;
      return m[IW-2:0];
   endfunction

   // Saturating add to the symmetric range of +-(2^63 - 1).
   function automatic logic [IW-1:0] sadd(logic [IW-1:0] a, logic [IW-1:0] b);
      logic signed [IW:0] s;
      logic [IW-1:0] r;
      s = $signed({a[IW-1], a}) + $signed({b[IW-1], b});
      if (s > SUM_MAX) begin
         r = SAT_MAX;
      end else if (s < SUM_MIN) begin
         r = neg64(SAT_MAX);
      end else begin
         r = s[IW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/rei_div_cell.sv]
// One restoring division cell: produces one quotient bit per cycle while en is high.
// Used by rei_div_chain; no package dependency.
`default_nettype none

module rei_div_cell #(
   parameter int DEN_W = 31,
   parameter int Q_W = 49,
   parameter int SB_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             vld_i,
   input  wire logic             ovf_i,
   input  wire logic [DEN_W-1:0] rem_i,
   input  wire logic [Q_W-1:0]   lo_i,
   input  wire logic [Q_W-1:0]   q_i,
   input  wire logic [DEN_W-1:0] den_i,
   input  wire logic [SB_W-1:0]  sb_i,
   output logic                  vld_o,
   output logic                  ovf_o,
   output logic [DEN_W-1:0]      rem_o,
   output logic [Q_W-1:0]        lo_o,
   output logic [Q_W-1:0]        q_o,
   output logic [DEN_W-1:0]      den_o,
   output logic [SB_W-1:0]       sb_o
);

   logic             vld_ff;
   logic             ovf_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   lo_ff, lo_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [DEN_W-1:0] den_ff;
   logic [SB_W-1:0]  sb_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_i, lo_i[Q_W-1]};
      diff   = trial - {1'b0, den_i};
      ge     = trial >= {1'b0, den_i};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_in  = {lo_i[Q_W-2:0], 1'b0};
      q_in   = {q_i[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff <= ovf_i;
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
         q_ff   <= q_in;
         den_ff <= den_i;
         sb_ff  <= sb_i;
      end
   end

   assign vld_o = vld_ff;
   assign ovf_o = ovf_ff;
   assign rem_o = rem_ff;
   assign lo_o  = lo_ff;
   assign q_o   = q_ff;
   assign den_o = den_ff;
   assign sb_o  = sb_ff;

endmodule

`default_nettype wire

[src/rei_div_chain.sv]
// Pipelined saturating divider: an overflow stage followed by a row of rei_div_cell.
// Returns min(floor(num / den), 2^Q_W - 1). Depends on rei_div_cell.
`default_nettype none

module rei_div_chain #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 31,
   parameter int Q_W = 49,
   parameter int SB_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_vld,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [SB_W-1:0]  sb,
   output logic                  out_vld,
   output logic [Q_W-1:0]        quo,
   output logic [SB_W-1:0]       sb_o
);

   localparam int CW = NUM_W + DEN_W;

   logic             c_vld [0:Q_W];
   logic             c_ovf [0:Q_W];
   logic [DEN_W-1:0] c_rem [0:Q_W];
   logic [Q_W-1:0]   c_lo  [0:Q_W];
   logic [Q_W-1:0]   c_q   [0:Q_W];
   logic [DEN_W-1:0] c_den [0:Q_W];
   logic [SB_W-1:0]  c_sb  [0:Q_W];

   logic             vld_ff;
   logic             ovf_ff, ovf_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   lo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [SB_W-1:0]  sb_ff;

   always_comb begin
      ovf_in = (CW'(num) >> Q_W) >= CW'(den);
      rem_in = DEN_W'(num >> Q_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff <= ovf_in;
         rem_ff <= rem_in;
         lo_ff  <= num[Q_W-1:0];
         den_ff <= den;
         sb_ff  <= sb;
      end
   end

   assign c_vld[0] = vld_ff;
   assign c_ovf[0] = ovf_ff;
   assign c_rem[0] = rem_ff;
   assign c_lo[0]  = lo_ff;
   assign c_q[0]   = '0;
   assign c_den[0] = den_ff;
   assign c_sb[0]  = sb_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_cell
      rei_div_cell #(.DEN_W(DEN_W), .Q_W(Q_W), .SB_W(SB_W)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .vld_i (c_vld[k]),
         .ovf_i (c_ovf[k]),
         .rem_i (c_rem[k]),
         .lo_i  (c_lo[k]),
         .q_i   (c_q[k]),
         .den_i (c_den[k]),
         .sb_i  (c_sb[k]),
         .vld_o (c_vld[k+1]),
         .ovf_o (c_ovf[k+1]),
         .rem_o (c_rem[k+1]),
         .lo_o  (c_lo[k+1]),
         .q_o   (c_q[k+1]),
         .den_o (c_den[k+1]),
         .sb_o  (c_sb[k+1])
      );
   end

   assign out_vld = c_vld[Q_W];
   assign quo     = c_ovf[Q_W] ? {Q_W{1'b1}} : c_q[Q_W];
   assign sb_o    = c_sb[Q_W];

endmodule

`default_nettype wire

[src/rei_sqrt_cell.sv]
// One digit-by-digit square root cell: produces one root bit per cycle while en is high.
// Instantiated as a row in the top level; no package dependency.
`default_nettype none

module rei_sqrt_cell #(
   parameter int RW = 40,
   parameter int SB_W = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              vld_i,
   input  wire logic [RW+1:0]     rem_i,
   input  wire logic [RW-1:0]     root_i,
   input  wire logic [2*RW-1:0]   op_i,
   input  wire logic [SB_W-1:0]   sb_i,
   output logic                   vld_o,
   output logic [RW+1:0]          rem_o,
   output logic [RW-1:0]          root_o,
   output logic [2*RW-1:0]        op_o,
   output logic [SB_W-1:0]        sb_o
);

   localparam int OPW = 2 * RW;

   logic            vld_ff;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [OPW-1:0]  op_ff, op_in;
   logic [SB_W-1:0] sb_ff;
   logic [RW+3:0]   trial;
   logic [RW+3:0]   tst;
   logic [RW+3:0]   diff;
   logic            ge;

   always_comb begin
      trial   = {rem_i, op_i[OPW-1:OPW-2]};
      tst     = {2'b00, root_i, 2'b01};
      diff    = trial - tst;
      ge      = trial >= tst;
      rem_in  = ge ? diff[RW+1:0] : trial[RW+1:0];
      root_in = {root_i[RW-2:0], ge};
      op_in   = {op_i[OPW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         op_ff   <= op_in;
         sb_ff   <= sb_i;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign op_o   = op_ff;
   assign sb_o   = sb_ff;

endmodule

`default_nettype wire

[src/rei_qmul.sv]
// Two-stage signed fixed-point multiplier with truncation and saturation.
// Partial products in the first stage, sum and scaling in the second. Uses rei_pkg.
`default_nettype none

module rei_qmul #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_vld,
   input  wire logic [63:0] x,
   input  wire logic [63:0] y,
   output logic             out_vld,
   output logic [63:0]      p
);

   localparam int PW = 126;

   logic        a_vld_ff, b_vld_ff;
   logic        neg_ff;
   logic [62:0] mx, my;
   logic [63:0] pll_ff, pll_in;
   logic [62:0] plh_ff, plh_in;
   logic [62:0] phl_ff, phl_in;
   logic [61:0] phh_ff, phh_in;
   logic [PW-1:0] sum;
   logic [PW-1:0] sh;
   logic [62:0]   mag_r;
   logic [63:0]   p_ff, p_in;

   always_comb begin
      mx     = rei_pkg::mag63(x);
      my     = rei_pkg::mag63(y);
      pll_in = mx[31:0] * my[31:0];
      plh_in = mx[31:0] * my[62:32];
      phl_in = mx[62:32] * my[31:0];
      phh_in = mx[62:32] * my[62:32];
   end

   always_comb begin
      sum   = PW'(pll_ff) + (PW'(plh_ff) << 32) + (PW'(phl_ff) << 32) + (PW'(phh_ff) << 64);
      sh    = sum >> FRAC_BITS;
      mag_r = (sh > PW'(rei_pkg::SAT_MAX)) ? rei_pkg::SAT_MAX[62:0] : sh[62:0];
      p_in  = neg_ff ? rei_pkg::neg64({1'b0, mag_r}) : {1'b0, mag_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= x[63] ^ y[63];
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phl_ff <= phl_in;
         phh_ff <= phh_in;
         p_ff   <= p_in;
      end
   end

   assign out_vld = b_vld_ff;
   assign p       = p_ff;

endmodule

`default_nettype wire

[src/ray_ellipsoid_intersect_top.sv]
// Ray against axis-aligned ellipsoid intersection, fully pipelined.
// Uses rei_pkg, rei_div_chain, rei_sqrt_cell, rei_qmul and assert_macros.svh.
//
// Usage:
//   Rays enter on the req_ channel (origin and direction, signed fixed point)
//   and each produces exactly one transaction on the rsp_ channel: hit flag,
//   near and far distance, in arrival order. On a miss both distances are -1.0.
//   Ellipsoid center and radii are written on the csr_ port (index 0 to 5,
//   center x/y/z then radius x/y/z); csr_ready is always high. The user must
//   make writes only while no ray is in flight; the block does not enforce it.
//   Throughput is one ray per cycle while req_stall is low. The pipeline depth is
//   set largely by the three rows of divider and square root cells, one result
//   bit per cell. Reset empties the pipeline and loads center 0 and radii 1.0.
//   When the receiver stalls, one more result is held in a second output
//   register; req_stall then rises and the whole pipeline holds its contents.
`default_nettype none
`include "assert_macros.svh"

module ray_ellipsoid_intersect_top #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [WORD_WIDTH-1:0]             req_origin_x,
   input  wire logic [WORD_WIDTH-1:0]             req_origin_y,
   input  wire logic [WORD_WIDTH-1:0]             req_origin_z,
   input  wire logic [WORD_WIDTH-1:0]             req_dir_x,
   input  wire logic [WORD_WIDTH-1:0]             req_dir_y,
   input  wire logic [WORD_WIDTH-1:0]             req_dir_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_hit,
   output logic [WORD_WIDTH-1:0]                  rsp_t_near,
   output logic [WORD_WIDTH-1:0]                  rsp_t_far,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rei_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [WORD_WIDTH-1:0]             csr_data
);

   localparam int W     = WORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int U_NW  = W + 1 + F;
   localparam int U_QW  = (U_NW < 63) ? U_NW : 63;
   localparam int U_NWP = (U_NW > U_QW) ? U_NW : U_QW + 1;
   localparam int RW    = (63 + F + 1) / 2;
   localparam int OPW   = 2 * RW;
   localparam int T_NW  = 63 + F;
   localparam int SQ_SB = 128;
   localparam logic [63:0]  C_INIT    = {64{1'b1}} << F;
   localparam logic [W-1:0] MINUS_ONE = {W{1'b1}} << F;
   localparam logic [W-2:0] RAD_ONE   = (W-1)'(1) << F;

   // Configuration registers.
   logic [W-1:0] center_ff [0:2];
   logic [W-2:0] radius_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
            radius_ff[i] <= RAD_ONE;
         end
      end else if (csr_valid) begin
         case (csr_index)
            rei_pkg::CSR_CENTER_X: center_ff[0] <= csr_data;
            rei_pkg::CSR_CENTER_Y: center_ff[1] <= csr_data;
            rei_pkg::CSR_CENTER_Z: center_ff[2] <= csr_data;
            rei_pkg::CSR_RADIUS_X: radius_ff[0] <= csr_data[W-2:0];
            rei_pkg::CSR_RADIUS_Y: radius_ff[1] <= csr_data[W-2:0];
            rei_pkg::CSR_RADIUS_Z: radius_ff[2] <= csr_data[W-2:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic adv;
   logic skid_vld_ff;
   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // Input stage: offsets from the center and magnitudes for the dividers.
   logic [W-1:0]     org [0:2];
   logic [W-1:0]     dir [0:2];
   logic             s0_vld_ff;
   logic [U_NWP-1:0] s0_num_ff [0:5];
   logic             s0_neg_ff [0:5];
   logic [W-2:0]     s0_den_ff [0:2];
   logic [W:0]       co [0:2];
   logic [W:0]       co_mag [0:2];
   logic [W-1:0]     dd_mag [0:2];

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         co[i]     = {org[i][W-1], org[i]} - {center_ff[i][W-1], center_ff[i]};
         co_mag[i] = co[i][W] ? ((W+1)'(0) - co[i]) : co[i];
         dd_mag[i] = dir[i][W-1] ? (W'(0) - dir[i]) : dir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s0_num_ff[i]   <= U_NWP'(co_mag[i]) << F;
            s0_neg_ff[i]   <= co[i][W];
            s0_num_ff[i+3] <= U_NWP'(dd_mag[i]) << F;
            s0_neg_ff[i+3] <= dir[i][W-1];
            s0_den_ff[i]   <= (radius_ff[i] == '0) ? (W-1)'(1) : radius_ff[i];
         end
      end
   end

   // Scaling by the radii: six divider rows.
   logic [5:0]      dv_vld;
   logic [5:0]      dv_neg;
   logic [U_QW-1:0] dv_quo [0:5];

   for (genvar i = 0; i < 6; i++) begin : g_scale
      rei_div_chain #(.NUM_W(U_NWP), .DEN_W(W-1), .Q_W(U_QW), .SB_W(1)) u_div (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .in_vld  (s0_vld_ff),
         .num     (s0_num_ff[i]),
         .den     (s0_den_ff[i % 3]),
         .sb      (s0_neg_ff[i]),
         .out_vld (dv_vld[i]),
         .quo     (dv_quo[i]),
         .sb_o    (dv_neg[i])
      );
   end

   logic        uv_vld_ff;
   logic [63:0] uv_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_vld_ff <= 1'b0;
      end else if (adv) begin
         uv_vld_ff <= &dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            uv_ff[i] <= dv_neg[i] ? rei_pkg::neg64(64'(dv_quo[i])) : 64'(dv_quo[i]);
         end
      end
   end

   // Products v*v, u*v and u*u for each axis.
   logic [8:0]  pr_vld;
   logic [63:0] pr [0:8];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rei_qmul #(.FRAC_BITS(F)) u_vv (
         .clock (clock), .reset (reset), .en (adv), .in_vld (uv_vld_ff),
         .x (uv_ff[i+3]), .y (uv_ff[i+3]), .out_vld (pr_vld[3*i]), .p (pr[3*i])
      );
      rei_qmul #(.FRAC_BITS(F)) u_uv (
         .clock (clock), .reset (reset), .en (adv), .in_vld (uv_vld_ff),
         .x (uv_ff[i]), .y (uv_ff[i+3]), .out_vld (pr_vld[3*i+1]), .p (pr[3*i+1])
      );
      rei_qmul #(.FRAC_BITS(F)) u_uu (
         .clock (clock), .reset (reset), .en (adv), .in_vld (uv_vld_ff),
         .x (uv_ff[i]), .y (uv_ff[i]), .out_vld (pr_vld[3*i+2]), .p (pr[3*i+2])
      );
   end

   // Saturating accumulation of a, b and c, one axis per stage.
   logic        ac1_vld_ff, ac2_vld_ff, ac3_vld_ff;
   logic [63:0] ac1_ff [0:2];
   logic [63:0] ac2_ff [0:2];
   logic [63:0] ac3_ff [0:2];
   logic [63:0] hold1_ff [0:5];
   logic [63:0] hold2_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_vld_ff <= 1'b0;
         ac2_vld_ff <= 1'b0;
         ac3_vld_ff <= 1'b0;
      end else if (adv) begin
         ac1_vld_ff <= &pr_vld;
         ac2_vld_ff <= ac1_vld_ff;
         ac3_vld_ff <= ac2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ac1_ff[0] <= pr[0];
         ac1_ff[1] <= pr[1];
         ac1_ff[2] <= rei_pkg::sadd(C_INIT, pr[2]);
         for (int k = 0; k < 6; k++) begin
            hold1_ff[k] <= pr[k+3];
         end
         for (int k = 0; k < 3; k++) begin
            ac2_ff[k]   <= rei_pkg::sadd(ac1_ff[k], hold1_ff[k]);
            hold2_ff[k] <= hold1_ff[k+3];
            ac3_ff[k]   <= rei_pkg::sadd(ac2_ff[k], hold2_ff[k]);
         end
      end
   end

   // Discriminant: b*b - a*c.
   logic        bb_vld, ac_vld;
   logic [63:0] bb_p, ac_p;
   logic [63:0] ab1_a_ff, ab1_b_ff, ab2_a_ff, ab2_b_ff;

   rei_qmul #(.FRAC_BITS(F)) u_bb (
      .clock (clock), .reset (reset), .en (adv), .in_vld (ac3_vld_ff),
      .x (ac3_ff[1]), .y (ac3_ff[1]), .out_vld (bb_vld), .p (bb_p)
   );
   rei_qmul #(.FRAC_BITS(F)) u_ac (
      .clock (clock), .reset (reset), .en (adv), .in_vld (ac3_vld_ff),
      .x (ac3_ff[0]), .y (ac3_ff[2]), .out_vld (ac_vld), .p (ac_p)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         ab1_a_ff <= ac3_ff[0];
         ab1_b_ff <= ac3_ff[1];
         ab2_a_ff <= ab1_a_ff;
         ab2_b_ff <= ab1_b_ff;
      end
   end

   logic        ds_vld_ff;
   logic        ds_miss_ff;
   logic [63:0] ds_d_ff, ds_a_ff, ds_b_ff;
   logic [63:0] d_in;

   always_comb begin
      d_in = rei_pkg::sadd(bb_p, rei_pkg::neg64(ac_p));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_vld_ff <= 1'b0;
      end else if (adv) begin
         ds_vld_ff <= bb_vld & ac_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_d_ff    <= d_in;
         ds_a_ff    <= ab2_a_ff;
         ds_b_ff    <= ab2_b_ff;
         ds_miss_ff <= ab2_a_ff[63] || (ab2_a_ff == '0) || d_in[63];
      end
   end

   // Square root row.
   logic             sq_vld  [0:RW];
   logic [RW+1:0]    sq_rem  [0:RW];
   logic [RW-1:0]    sq_root [0:RW];
   logic [OPW-1:0]   sq_op   [0:RW];
   logic [SQ_SB-1:0] sq_sb   [0:RW];

   assign sq_vld[0]  = ds_vld_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_op[0]   = ds_miss_ff ? '0 : (OPW'(ds_d_ff[62:0]) << F);
   assign sq_sb[0]   = {ds_miss_ff, ds_a_ff[62:0], ds_b_ff};

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      rei_sqrt_cell #(.RW(RW), .SB_W(SQ_SB)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (adv),
         .vld_i  (sq_vld[k]),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .op_i   (sq_op[k]),
         .sb_i   (sq_sb[k]),
         .vld_o  (sq_vld[k+1]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1]),
         .op_o   (sq_op[k+1]),
         .sb_o   (sq_sb[k+1])
      );
   end

   // Numerators -b - s and -b + s.
   logic        nm_vld_ff;
   logic        nm_miss_ff, nm_neg1_ff, nm_neg2_ff;
   logic [62:0] nm_mag1_ff, nm_mag2_ff, nm_a_ff;
   logic [63:0] sq_s, nb, n1, n2;

   always_comb begin
      sq_s = 64'(sq_root[RW]);
      nb   = rei_pkg::neg64(sq_sb[RW][63:0]);
      n1   = rei_pkg::sadd(nb, rei_pkg::neg64(sq_s));
      n2   = rei_pkg::sadd(nb, sq_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff <= 1'b0;
      end else if (adv) begin
         nm_vld_ff <= sq_vld[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_miss_ff <= sq_sb[RW][127];
         nm_a_ff    <= sq_sb[RW][126:64];
         nm_neg1_ff <= n1[63];
         nm_neg2_ff <= n2[63];
         nm_mag1_ff <= rei_pkg::mag63(n1);
         nm_mag2_ff <= rei_pkg::mag63(n2);
      end
   end

   // Division of both numerators by a.
   logic [1:0]   tv_vld;
   logic [W-1:0] tq1, tq2;
   logic [1:0]   t1_sb;
   logic         t2_neg;

   rei_div_chain #(.NUM_W(T_NW), .DEN_W(63), .Q_W(W), .SB_W(2)) u_div_near (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (nm_vld_ff),
      .num     (T_NW'(nm_mag1_ff) << F),
      .den     (nm_a_ff),
      .sb      ({nm_miss_ff, nm_neg1_ff}),
      .out_vld (tv_vld[0]),
      .quo     (tq1),
      .sb_o    (t1_sb)
   );

   rei_div_chain #(.NUM_W(T_NW), .DEN_W(63), .Q_W(W), .SB_W(1)) u_div_far (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (nm_vld_ff),
      .num     (T_NW'(nm_mag2_ff) << F),
      .den     (nm_a_ff),
      .sb      (nm_neg2_ff),
      .out_vld (tv_vld[1]),
      .quo     (tq2),
      .sb_o    (t2_neg)
   );

   function automatic logic [W-1:0] t_word(logic [W-1:0] q, logic neg);
      logic [W-1:0] r;
      if (neg) begin
         r = q[W-1] ? {1'b1, {(W-1){1'b0}}} : (W'(0) - q);
      end else begin
         r = q[W-1] ? {1'b0, {(W-1){1'b1}}} : q;
      end
      return r;
   endfunction

   logic         fin_vld;
   logic         fin_hit;
   logic [W-1:0] fin_near, fin_far;

   always_comb begin
      fin_vld  = &tv_vld;
      fin_hit  = !t1_sb[1];
      fin_near = t1_sb[1] ? MINUS_ONE : t_word(tq1, t1_sb[0]);
      fin_far  = t1_sb[1] ? MINUS_ONE : t_word(tq2, t2_neg);
   end

   // Output register and skid register.
   logic         rsp_valid_ff;
   logic         rsp_hit_ff, skid_hit_ff;
   logic [W-1:0] rsp_near_ff, rsp_far_ff, skid_near_ff, skid_far_ff;
   logic         rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= skid_vld_ff || fin_vld;
         skid_vld_ff  <= 1'b0;
      end else if (adv && fin_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_vld_ff) begin
            rsp_hit_ff  <= skid_hit_ff;
            rsp_near_ff <= skid_near_ff;
            rsp_far_ff  <= skid_far_ff;
         end else begin
            rsp_hit_ff  <= fin_hit;
            rsp_near_ff <= fin_near;
            rsp_far_ff  <= fin_far;
         end
      end else if (adv) begin
         skid_hit_ff  <= fin_hit;
         skid_near_ff <= fin_near;
         skid_far_ff  <= fin_far;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_t_near = rsp_near_ff;
   assign rsp_t_far  = rsp_far_ff;

   `REI_ASSERT(a_skid_behind_rsp, clock, reset, (skid_vld_ff |-> rsp_valid_ff))
   `REI_ASSERT(a_hit_ordered, clock, reset, ((rsp_valid_ff && rsp_hit_ff) |-> ($signed(rsp_near_ff) <= $signed(rsp_far_ff))))
   `REI_ASSERT(a_miss_minus_one, clock, reset, ((rsp_valid_ff && !rsp_hit_ff) |-> (rsp_near_ff == MINUS_ONE && rsp_far_ff == MINUS_ONE)))
   `REI_ASSERT_NORST(a_reset_empty, clock, (reset |=> (!rsp_valid_ff && !skid_vld_ff)))

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for ray_ellipsoid_intersect_top: drives rays, predicts
// each hit flag and root pair in 64-bit fixed point, and checks every response.
// Depends on rei_pkg and the RTL under src.
`default_nettype none

module tb_top;

   localparam int F = 16;
   localparam int W = 32;
   localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam logic [rei_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [rei_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B = 3'd7;
   localparam int LATENCY = 134;

   typedef logic signed [63:0] q64_type;
   typedef struct packed {
      logic [2:0][W-1:0] org;
      logic [2:0][W-1:0] dir;
   } ray_type;
   typedef struct packed {
      logic hit;
      logic [W-1:0] t_near;
      logic [W-1:0] t_far;
   } hit_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [W-1:0] req_origin_x, req_origin_y, req_origin_z;
   logic [W-1:0] req_dir_x, req_dir_y, req_dir_z;
   logic rsp_valid, rsp_stall, rsp_hit;
   logic [W-1:0] rsp_t_near, rsp_t_far;
   logic csr_valid, csr_ready;
   logic [rei_pkg::CSR_IDX_W-1:0] csr_index;
   logic [W-1:0] csr_data;

   logic [W-1:0] center [3];
   logic [W-2:0] radius [3];
   hit_type expected_hits[$];
   int errors = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b1;

   always #2 clock = ~clock;

   ray_ellipsoid_intersect_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_t_near(rsp_t_near), .rsp_t_far(rsp_t_far),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic q64_type sat_sum(q64_type a, q64_type b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, QMAX})) return QMAX;
      if (s < -$signed({1'b0, QMAX})) return -QMAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] abs64(q64_type x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   function automatic q64_type fix_mul(q64_type x, q64_type y);
      logic [127:0] p;
      logic [63:0] r;
      p = ({64'd0, abs64(x)} * {64'd0, abs64(y)}) >> F;
      r = (p > {64'd0, QMAX}) ? QMAX : p[63:0];
      return (x[63] != y[63]) ? -$signed(r) : $signed(r);
   endfunction

   function automatic q64_type fix_div(bit neg, logic [63:0] m, logic [63:0] d);
      logic [127:0] q;
      logic [63:0] r;
      q = ({64'd0, m} << F) / {64'd0, d};
      r = (q > {64'd0, QMAX}) ? QMAX : q[63:0];
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic q64_type fix_sqrt(q64_type x);
      logic [127:0] v;
      logic [63:0] s, c;
      s = 64'd0;
      v = {64'd0, x} << F;
      for (int k = 63; k >= 0; k--) begin
         c = s | (64'd1 << k);
         if ({64'd0, c} * {64'd0, c} <= v) s = c;
      end
      return (s > QMAX) ? QMAX : s;
   endfunction

   function automatic logic [W-1:0] clamp_word(q64_type t);
      if (t > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (t < -64'sh8000_0000) return 32'h8000_0000;
      return t[W-1:0];
   endfunction

   function automatic hit_type predict_hit(ray_type ray);
      q64_type u, v, co, dd, a, b, c, d, s, n1, n2;
      logic [63:0] r;
      hit_type h;
      a = 0;
      b = 0;
      c = -64'sd65536;
      for (int i = 0; i < 3; i++) begin
         co = $signed(ray.org[i]) - $signed(center[i]);
         dd = $signed(ray.dir[i]);
         r = (radius[i] == 0) ? 64'd1 : {33'd0, radius[i]};
         u = fix_div(co[63], abs64(co), r);
         v = fix_div(dd[63], abs64(dd), r);
         a = sat_sum(a, fix_mul(v, v));
         b = sat_sum(b, fix_mul(u, v));
         c = sat_sum(c, fix_mul(u, u));
      end
      d = sat_sum(fix_mul(b, b), -fix_mul(a, c));
      if (a <= 0 || d < 0) begin
         h.hit = 1'b0;
         h.t_near = -ONE;
         h.t_far = -ONE;
      end else begin
         s = fix_sqrt(d);
         n1 = sat_sum(-b, -s);
         n2 = sat_sum(-b, s);
         h.hit = 1'b1;
         h.t_near = clamp_word(fix_div(n1[63], abs64(n1), a));
         h.t_far = clamp_word(fix_div(n2[63], abs64(n2), a));
      end
      return h;
   endfunction

   task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] exp);
      $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, exp);
      errors++;
   endtask

   always @(posedge clock) begin
      hit_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: response transaction with nothing expected", $time);
            errors++;
         end else begin
            exp = expected_hits.pop_front();
            if (rsp_hit !== exp.hit) report_mismatch("hit", W'(rsp_hit), W'(exp.hit));
            if (rsp_t_near !== exp.t_near) report_mismatch("t_near", rsp_t_near, exp.t_near);
            if (rsp_t_far !== exp.t_far) report_mismatch("t_far", rsp_t_far, exp.t_far);
         end
      end
   end

   always @(posedge clock) begin
      int hold_cnt;
      if (hold_request > 0) begin
         hold_cnt = hold_request;
         hold_request = 0;
      end
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_ray(ray_type ray);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_origin_x, req_origin_y, req_origin_z} <= {ray.org[0], ray.org[1], ray.org[2]};
      {req_dir_x, req_dir_y, req_dir_z} <= {ray.dir[0], ray.dir[1], ray.dir[2]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_hits.push_back(predict_hit(ray));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [rei_pkg::CSR_IDX_W-1:0] idx, logic [W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         rei_pkg::CSR_CENTER_X: center[0] = value;
         rei_pkg::CSR_CENTER_Y: center[1] = value;
         rei_pkg::CSR_CENTER_Z: center[2] = value;
         rei_pkg::CSR_RADIUS_X: radius[0] = value[W-2:0];
         rei_pkg::CSR_RADIUS_Y: radius[1] = value[W-2:0];
         rei_pkg::CSR_RADIUS_Z: radius[2] = value[W-2:0];
         default: ;
      endcase
   endtask

   task automatic set_ellipsoid(logic [W-1:0] cx, logic [W-1:0] cy, logic [W-1:0] cz,
                                logic [W-1:0] rx, logic [W-1:0] ry, logic [W-1:0] rz);
      drain();
      write_csr(rei_pkg::CSR_CENTER_X, cx);
      write_csr(rei_pkg::CSR_CENTER_Y, cy);
      write_csr(rei_pkg::CSR_CENTER_Z, cz);
      write_csr(rei_pkg::CSR_RADIUS_X, rx);
      write_csr(rei_pkg::CSR_RADIUS_Y, ry);
      write_csr(rei_pkg::CSR_RADIUS_Z, rz);
   endtask

   function automatic ray_type make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      ray_type r;
      r.org = {oz, oy, ox};
      r.dir = {dz, dy, dx};
      return r;
   endfunction

   function automatic ray_type noise_ray();
      ray_type r;
      for (int i = 0; i < 3; i++) begin
         r.org[i] = $urandom;
         r.dir[i] = $urandom;
      end
      return r;
   endfunction

   // Origin 0 to 4 radii above the center per axis, aimed at a point near it.
   function automatic ray_type aimed_ray();
      ray_type r;
      q64_type span, o, t, dv;
      for (int i = 0; i < 3; i++) begin
         span = (radius[i] == 0) ? 64'sd1 : $signed(64'(radius[i]));
         o = $signed(center[i]) + (($signed(64'($urandom)) % (4 * span + 1)));
         t = $signed(center[i]) + (($signed(64'($urandom)) % (span + 1)) >>> 1);
         r.org[i] = o[W-1:0];
         dv = ($urandom_range(0, 3) == 0) ? (t - o) : ((t - o) >>> $urandom_range(1, 6));
         r.dir[i] = dv[W-1:0];
      end
      return r;
   endfunction

   task automatic test_directed_unit_sphere();
      send_ray(make_ray(-2 * ONE, 0, 0, ONE, 0, 0));
      send_ray(make_ray(-2 * ONE, ONE, 0, ONE, 0, 0));
      send_ray(make_ray(-2 * ONE, 2 * ONE, 0, ONE, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, ONE, 0));
      send_ray(make_ray(3 * ONE, 0, 0, ONE, 0, 0));
      send_ray(make_ray(0, 0, -5 * ONE, 0, 0, ONE / 4));
      send_ray(make_ray(ONE, ONE, ONE, 0, 0, 0));
      send_ray(make_ray(0, 0, 0, 1, 0, 1));
      send_ray(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1, -1, -1));
      send_ray(make_ray(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0));
      send_ray(make_ray(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      send_ray(make_ray(-ONE / 2, 0, 0, 1, 0, 0));
      send_ray(make_ray(0, -3 * ONE, 0, 0, 32'sh7FFF_FFFF, 0));
   endtask

   task automatic test_register_extremes();
      set_ellipsoid(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1, 32'h7FFF_FFFF);
      write_csr(CSR_UNUSED_A, 32'h1234_5678);
      write_csr(CSR_UNUSED_B, 32'hFFFF_FFFF);
      send_ray(make_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, ONE));
      send_ray(make_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 1, 1));
      send_ray(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, ONE, -ONE, 0));
      set_ellipsoid(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_ray(make_ray(0, 0, 0, ONE, ONE, ONE));
      send_ray(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1));
      set_ellipsoid(ONE, -ONE, 2 * ONE, ONE / 2, 2 * ONE, 3 * ONE);
      send_ray(make_ray(ONE, -ONE, -6 * ONE, 0, 0, ONE));
      send_ray(make_ray(-3 * ONE, -ONE, 2 * ONE, ONE, 0, 0));
   endtask

   task automatic test_random_rays(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         set_ellipsoid($signed($urandom) >>> $urandom_range(7, 16),
                       $signed($urandom) >>> $urandom_range(7, 16),
                       $signed($urandom) >>> $urandom_range(7, 16),
                       $urandom_range(ONE / 16, ONE * 8), $urandom_range(ONE / 16, ONE * 8),
                       $urandom_range(ONE / 16, ONE * 8));
         stall_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 60);
         sender_gaps = (p % 4 != 1);
         for (int i = 0; i < per_phase; i++) begin
            send_ray(($urandom_range(0, 9) == 0) ? noise_ray() : aimed_ray());
         end
      end
   endtask

   task automatic test_noise_rays(int count);
      stall_pct = 30;
      sender_gaps = 1'b1;
      for (int i = 0; i < count; i++) send_ray(noise_ray());
   endtask

   task automatic test_backpressure();
      set_ellipsoid(0, 0, 0, 2 * ONE, ONE, 3 * ONE);
      stall_pct = 0;
      sender_gaps = 1'b0;
      hold_request = 400;
      for (int i = 0; i < 250; i++) send_ray(aimed_ray());
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      {req_origin_x, req_origin_y, req_origin_z} <= '0;
      {req_dir_x, req_dir_y, req_dir_z} <= '0;
      csr_valid <= 1'b0;
      csr_index <= rei_pkg::CSR_CENTER_X;
      csr_data <= '0;
      rsp_stall <= 1'b0;
      for (int i = 0; i < 3; i++) begin
         center[i] = '0;
         radius[i] = ONE[W-2:0];
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_unit_sphere();
      test_register_extremes();
      test_random_rays(24, 50);
      test_noise_rays(200);
      test_backpressure();
      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
